// File: sv/jmsd_pkg.sv
// Package: shared constants, codes and types for the joint motion settle detector.
`timescale 1ns / 1ps

package jmsd_pkg;

  localparam int unsigned ANGLE_W           = 16;
  localparam int unsigned TOL_W             = 15;
  localparam int unsigned KEEP_W            = 7;
  localparam int unsigned JOINT_FIELDS      = 7;
  localparam int unsigned JOINT_COUNT_DEF   = 7;
  localparam int unsigned HISTORY_DEPTH_DEF = 10;
  localparam int unsigned CFG_IDX_W         = 1;
  localparam int unsigned CFG_DATA_W        = TOL_W;

  localparam logic [TOL_W-1:0] REACH_TOL_RST  = TOL_W'(123);
  localparam logic [TOL_W-1:0] MOTION_TOL_RST = TOL_W'(41);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REACH_TOL  = 1'b0,
    REG_MOTION_TOL = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    MODE_SAMPLE  = 1'b0,
    MODE_COMMAND = 1'b1
  } mode_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_FILL  = 5'b00010,
    ST_REACH = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_PUSH  = 5'b10000
  } state_t;

  typedef struct packed {
    logic target_reached;
    logic motion_started;
    logic still_moving;
  } result_t;

endpackage

// File: sv/jmsd_if.sv
// Interfaces: request channel for joint items and result channel for settle status.
`timescale 1ns / 1ps

interface jmsd_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 mode;
  logic signed [jmsd_pkg::ANGLE_W-1:0]  joint0;
  logic signed [jmsd_pkg::ANGLE_W-1:0]  joint1;
  logic signed [jmsd_pkg::ANGLE_W-1:0]  joint2;
  logic signed [jmsd_pkg::ANGLE_W-1:0]  joint3;
  logic signed [jmsd_pkg::ANGLE_W-1:0]  joint4;
  logic signed [jmsd_pkg::ANGLE_W-1:0]  joint5;
  logic signed [jmsd_pkg::ANGLE_W-1:0]  joint6;
  logic        [jmsd_pkg::KEEP_W-1:0]   keep_mask;

  modport source (output valid, mode, joint0, joint1, joint2, joint3, joint4, joint5,
                  joint6, keep_mask, input ready);
  modport sink   (input valid, mode, joint0, joint1, joint2, joint3, joint4, joint5,
                  joint6, keep_mask, output ready);
endinterface

interface jmsd_out_if;
  logic valid;
  logic ready;
  logic target_reached;
  logic motion_started;
  logic still_moving;

  modport source (output valid, target_reached, motion_started, still_moving, input ready);
  modport sink   (input valid, target_reached, motion_started, still_moving, output ready);
endinterface

// File: sv/jmsd_dev_unit.sv
// Shared deviation unit: per-joint absolute difference compared against a tolerance.
`timescale 1ns / 1ps

module jmsd_dev_unit #(
  parameter int unsigned LANES = jmsd_pkg::JOINT_COUNT_DEF
) (
  input  logic [LANES-1:0][jmsd_pkg::ANGLE_W-1:0] a_i,
  input  logic [LANES-1:0][jmsd_pkg::ANGLE_W-1:0] b_i,
  input  logic [jmsd_pkg::TOL_W-1:0]              tol_i,
  output logic                                    dev_o
);

  localparam int unsigned DW = jmsd_pkg::ANGLE_W + 1;

  logic [LANES-1:0] over;
  logic [DW-1:0]    tol_ext;

  assign tol_ext = {{(DW - jmsd_pkg::TOL_W){1'b0}}, tol_i};

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    logic signed [DW-1:0] diff;
    logic        [DW-1:0] mag;
    assign diff    = $signed({a_i[j][jmsd_pkg::ANGLE_W-1], a_i[j]})
                   - $signed({b_i[j][jmsd_pkg::ANGLE_W-1], b_i[j]});
    assign mag     = diff[DW-1] ? $unsigned(-diff) : $unsigned(diff);
    assign over[j] = mag > tol_ext;
  end

  assign dev_o = |over;

endmodule

// File: sv/jmsd_hist_mem.sv
// Position history memory: one write port, one registered read port.
`timescale 1ns / 1ps

module jmsd_hist_mem #(
  parameter int unsigned DEPTH = jmsd_pkg::HISTORY_DEPTH_DEF,
  parameter int unsigned WIDTH = jmsd_pkg::JOINT_COUNT_DEF * jmsd_pkg::ANGLE_W,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: sv/joint_motion_settle_detector_core.sv
// Top level: sequencer, state registers and result register of the settle detector.
// Sequence: command IDLE, PUSH; sample within reach tolerance IDLE, REACH, PUSH; other samples
//   IDLE, REACH, SCAN over k history entries (stops at first moving entry, max HISTORY_DEPTH), PUSH.
// First sample after reset: IDLE, FILL over all HISTORY_DEPTH rows, PUSH (one history row written per cycle).
// Throughput: one item at a time; the history scan reads one row per cycle through the
//   single memory read port and the shared deviation unit.
// Reset (rst_n low, synchronous): idle, awaiting first sample, started cleared, tolerances 123/41.
`timescale 1ns / 1ps

module joint_motion_settle_detector_core #(
  parameter int unsigned JOINT_COUNT   = jmsd_pkg::JOINT_COUNT_DEF,
  parameter int unsigned HISTORY_DEPTH = jmsd_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [jmsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [jmsd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  jmsd_in_if.sink                           in_ch,
  jmsd_out_if.source                        out_ch
);

  localparam int unsigned AW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned ROW_W = JOINT_COUNT * jmsd_pkg::ANGLE_W;
  localparam logic [AW-1:0] LAST = AW'(HISTORY_DEPTH - 1);

  typedef logic [JOINT_COUNT-1:0][jmsd_pkg::ANGLE_W-1:0] row_t;

  jmsd_pkg::state_t  state_r, state_nxt;
  logic [AW-1:0]     cnt_r, cnt_nxt;
  logic [AW-1:0]     wptr_r, wptr_nxt;
  row_t              cur_r, cur_nxt;
  row_t              tgt_r, tgt_nxt;
  logic              awaiting_r, awaiting_nxt;
  logic              started_r, started_nxt;
  jmsd_pkg::result_t res_r, res_nxt;
  jmsd_pkg::result_t out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [jmsd_pkg::TOL_W-1:0] reach_tol_r, motion_tol_r;

  logic [jmsd_pkg::JOINT_FIELDS-1:0][jmsd_pkg::ANGLE_W-1:0] joint_fields;
  row_t                  in_row;
  logic [JOINT_COUNT-1:0] keep_row;
  logic                  accept;
  logic                  is_cmd;
  logic                  scanning;
  logic                  dev;
  row_t                  dev_a, dev_b;
  logic [jmsd_pkg::TOL_W-1:0] dev_tol;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  row_t                  hist_rdata;

  assign joint_fields = {in_ch.joint6, in_ch.joint5, in_ch.joint4, in_ch.joint3,
                         in_ch.joint2, in_ch.joint1, in_ch.joint0};

  for (genvar j = 0; j < JOINT_COUNT; j++) begin : g_map
    if (j < jmsd_pkg::JOINT_FIELDS) begin : g_field
      assign in_row[j]   = joint_fields[j];
      assign keep_row[j] = in_ch.keep_mask[j];
    end else begin : g_extra
      assign in_row[j]   = '0;
      assign keep_row[j] = 1'b1;
    end
  end

  assign in_ch.ready = (state_r == jmsd_pkg::ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_cmd      = (in_ch.mode == jmsd_pkg::MODE_COMMAND);
  assign scanning    = (state_r == jmsd_pkg::ST_SCAN);

  // shared unit: target check in REACH, history row check in SCAN
  assign dev_a   = scanning ? hist_rdata : cur_r;
  assign dev_b   = scanning ? cur_r : tgt_r;
  assign dev_tol = scanning ? motion_tol_r : reach_tol_r;

  jmsd_dev_unit #(
    .LANES (JOINT_COUNT)
  ) u_dev (
    .a_i   (dev_a),
    .b_i   (dev_b),
    .tol_i (dev_tol),
    .dev_o (dev)
  );

  assign mem_waddr = (state_r == jmsd_pkg::ST_FILL) ? cnt_r : wptr_r;
  assign mem_raddr = (scanning && cnt_r != LAST) ? cnt_r + AW'(1) : '0;

  jmsd_hist_mem #(
    .DEPTH (HISTORY_DEPTH),
    .WIDTH (ROW_W)
  ) u_hist (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (cur_r),
    .raddr (mem_raddr),
    .rdata (hist_rdata)
  );

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    wptr_nxt     = wptr_r;
    cur_nxt      = cur_r;
    tgt_nxt      = tgt_r;
    awaiting_nxt = awaiting_r;
    started_nxt  = started_r;
    res_nxt      = res_r;
    out_nxt      = out_r;
    out_valid_nxt = (out_valid_r && !out_ch.ready);
    mem_we       = 1'b0;
    case (state_r)
      jmsd_pkg::ST_IDLE: begin
        if (accept) begin
          cnt_nxt = '0;
          if (is_cmd) begin
            for (int j = 0; j < JOINT_COUNT; j++) begin
              if (!keep_row[j]) tgt_nxt[j] = in_row[j];
            end
            started_nxt = 1'b0;
            res_nxt     = '0;
            state_nxt   = jmsd_pkg::ST_PUSH;
          end else if (awaiting_r) begin
            cur_nxt      = in_row;
            tgt_nxt      = in_row;
            awaiting_nxt = 1'b0;
            res_nxt      = '{target_reached: 1'b1, motion_started: started_r,
                             still_moving: 1'b0};
            state_nxt    = jmsd_pkg::ST_FILL;
          end else begin
            // oldest slot takes the previous position
            mem_we    = 1'b1;
            wptr_nxt  = (wptr_r == LAST) ? '0 : wptr_r + AW'(1);
            cur_nxt   = in_row;
            state_nxt = jmsd_pkg::ST_REACH;
          end
        end
      end
      jmsd_pkg::ST_FILL: begin
        mem_we = 1'b1;
        if (cnt_r == LAST) begin
          state_nxt = jmsd_pkg::ST_PUSH;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      jmsd_pkg::ST_REACH: begin
        if (!dev) begin
          res_nxt   = '{target_reached: 1'b1, motion_started: started_r,
                        still_moving: 1'b0};
          state_nxt = jmsd_pkg::ST_PUSH;
        end else begin
          state_nxt = jmsd_pkg::ST_SCAN;
        end
      end
      jmsd_pkg::ST_SCAN: begin
        if (dev || cnt_r == LAST) begin
          started_nxt = started_r | dev;
          res_nxt     = '{target_reached: started_r & ~dev,
                          motion_started: started_r | dev,
                          still_moving: dev};
          state_nxt   = jmsd_pkg::ST_PUSH;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      jmsd_pkg::ST_PUSH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = jmsd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = jmsd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= jmsd_pkg::ST_IDLE;
      cnt_r        <= '0;
      wptr_r       <= '0;
      awaiting_r   <= 1'b1;
      started_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      reach_tol_r  <= jmsd_pkg::REACH_TOL_RST;
      motion_tol_r <= jmsd_pkg::MOTION_TOL_RST;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      wptr_r      <= wptr_nxt;
      awaiting_r  <= awaiting_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          jmsd_pkg::REG_REACH_TOL:  reach_tol_r  <= cfg_wdata;
          jmsd_pkg::REG_MOTION_TOL: motion_tol_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    tgt_r <= tgt_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.target_reached = out_r.target_reached;
  assign out_ch.motion_started = out_r.motion_started;
  assign out_ch.still_moving   = out_r.still_moving;

  a_moving_not_reached: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.still_moving) |-> !out_r.target_reached)
    else $error("moving result also flagged reached");

  a_moving_implies_started: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.still_moving) |-> out_r.motion_started)
    else $error("moving result without motion started");

  a_first_sample_once: assert property (@(posedge clk) disable iff (!rst_n)
    !awaiting_r |=> !awaiting_r)
    else $error("awaiting first sample set again");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (scanning || state_r == jmsd_pkg::ST_FILL) |-> (cnt_r <= LAST))
    else $error("history counter out of range");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != jmsd_pkg::ST_IDLE))
    else $error("request accepted without leaving idle");

endmodule

// File: tb/tb_top.sv
// Testbench: settle status of the joint motion settle detector checked against a predictor.
`timescale 1ns / 1ps

module tb_top;

  localparam int JN         = jmsd_pkg::JOINT_FIELDS;
  localparam int HD         = jmsd_pkg::HISTORY_DEPTH_DEF;
  localparam int CYCLE_CAP  = 400000;
  localparam int PHASE_SIZE = 275;

  typedef logic [JN-1:0][jmsd_pkg::ANGLE_W-1:0] pose_t;

  typedef struct packed {
    jmsd_pkg::mode_t             mode;
    pose_t                       joint;
    logic [jmsd_pkg::KEEP_W-1:0] keep;
  } hand_req_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [jmsd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [jmsd_pkg::CFG_DATA_W-1:0] cfg_wdata;

  jmsd_in_if  in_ch ();
  jmsd_out_if out_ch ();

  joint_motion_settle_detector_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // predictor state
  pose_t                      pos_now;
  pose_t                      pos_trail [HD];
  pose_t                      goal_pose;
  bit                         need_first_sample = 1'b1;
  bit                         seen_motion = 1'b0;
  bit                         settled = 1'b0;
  logic [jmsd_pkg::TOL_W-1:0] reach_tol = jmsd_pkg::REACH_TOL_RST;
  logic [jmsd_pkg::TOL_W-1:0] motion_tol = jmsd_pkg::MOTION_TOL_RST;

  jmsd_pkg::result_t status_due [$];
  int      err_cnt = 0;
  int      items_sent = 0;
  int      cycle_cnt = 0;
  int      in_idle_pct = 0;
  int      out_stall_pct = 0;
  int      hold_left = 0;
  bit      in_offer = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit pose_apart(pose_t a, pose_t b, logic [jmsd_pkg::TOL_W-1:0] tol);
    int d;
    for (int j = 0; j < JN; j++) begin
      d = int'($signed(a[j])) - int'($signed(b[j]));
      if (d < 0) d = -d;
      if (d > int'(tol)) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic jmsd_pkg::result_t predict_settle_status(hand_req_t r);
    jmsd_pkg::result_t res;
    bit                moving;
    res = '0;
    moving = 1'b0;
    if (r.mode == jmsd_pkg::MODE_COMMAND) begin
      for (int j = 0; j < JN; j++) begin
        if (!r.keep[j]) goal_pose[j] = r.joint[j];
      end
      settled = 1'b0;
      seen_motion = 1'b0;
      return res;
    end
    if (need_first_sample) begin
      for (int h = 0; h < HD; h++) pos_trail[h] = r.joint;
      goal_pose = r.joint;
      need_first_sample = 1'b0;
    end else begin
      for (int h = 0; h + 1 < HD; h++) pos_trail[h] = pos_trail[h+1];
      pos_trail[HD-1] = pos_now;
    end
    pos_now = r.joint;
    settled = !pose_apart(r.joint, goal_pose, reach_tol);
    if (!settled) begin
      for (int h = 0; h < HD; h++) begin
        if (pose_apart(pos_trail[h], pos_now, motion_tol)) moving = 1'b1;
      end
      if (!seen_motion && moving) seen_motion = 1'b1;
      else if (seen_motion && !moving) settled = 1'b1;
    end
    res.target_reached = settled;
    res.motion_started = seen_motion;
    res.still_moving   = moving;
    return res;
  endfunction

  function automatic void note_mismatch(string what, int exp_v, int got_v);
    err_cnt++;
    if (err_cnt <= 10)
      $display("%0t mismatch: %s expected %0d got %0d", $realtime, what, exp_v, got_v);
  endfunction

  function automatic int rand_offset(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic pose_t flat_pose(int v);
    pose_t p;
    for (int j = 0; j < JN; j++) p[j] = jmsd_pkg::ANGLE_W'(v);
    return p;
  endfunction

  function automatic hand_req_t hand_item(jmsd_pkg::mode_t m, pose_t p,
                                          logic [jmsd_pkg::KEEP_W-1:0] k);
    hand_req_t r;
    r.mode = m;
    r.joint = p;
    r.keep = k;
    return r;
  endfunction

  task automatic send_item(hand_req_t r);
    jmsd_pkg::result_t due;
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= r.mode;
    in_ch.joint0    <= r.joint[0];
    in_ch.joint1    <= r.joint[1];
    in_ch.joint2    <= r.joint[2];
    in_ch.joint3    <= r.joint[3];
    in_ch.joint4    <= r.joint[4];
    in_ch.joint5    <= r.joint[5];
    in_ch.joint6    <= r.joint[6];
    in_ch.keep_mask <= r.keep;
    in_offer = 1'b1;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    due = predict_settle_status(r);
    status_due = {status_due, due};
    items_sent++;
    if ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      in_offer = 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < in_idle_pct) @(posedge clk);
    end
  endtask

  task automatic settle_drain();
    if (in_offer) begin
      in_ch.valid <= 1'b0;
      in_offer = 1'b0;
    end
    while (status_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_tolerances(logic [jmsd_pkg::TOL_W-1:0] reach,
                                  logic [jmsd_pkg::TOL_W-1:0] motion);
    cfg_we    <= 1'b1;
    cfg_index <= jmsd_pkg::REG_REACH_TOL;
    cfg_wdata <= reach;
    @(posedge clk);
    reach_tol = reach;
    cfg_index <= jmsd_pkg::REG_MOTION_TOL;
    cfg_wdata <= motion;
    @(posedge clk);
    motion_tol = motion;
    cfg_we <= 1'b0;
  endtask

  // command, approach, then hold still; cut ends it after a few samples
  task automatic send_move(bit cut);
    hand_req_t cmd;
    pose_t     start, finish, p;
    int        span, steps, hold, s0, f0;
    start = pos_now;
    span = $urandom_range(1) ? 2000 : 32767;
    cmd.mode = jmsd_pkg::MODE_COMMAND;
    cmd.keep = $urandom_range(1) ? '0 : jmsd_pkg::KEEP_W'($urandom);
    for (int j = 0; j < JN; j++)
      cmd.joint[j] = jmsd_pkg::ANGLE_W'(int'($signed(start[j])) + rand_offset(span));
    send_item(cmd);
    for (int j = 0; j < JN; j++) begin
      if ($urandom_range(1))
        finish[j] = jmsd_pkg::ANGLE_W'(int'($signed(goal_pose[j]))
                                       + rand_offset(int'(reach_tol)));
      else
        finish[j] = jmsd_pkg::ANGLE_W'(int'($signed(goal_pose[j]))
                                       + rand_offset(3 * int'(reach_tol) + 200));
    end
    steps = $urandom_range(1, 6);
    hold  = cut ? 0 : $urandom_range(6, 13);
    if (cut) steps = $urandom_range(1, 3);
    for (int s = 1; s <= steps; s++) begin
      for (int j = 0; j < JN; j++) begin
        s0 = int'($signed(start[j]));
        f0 = int'($signed(finish[j]));
        p[j] = jmsd_pkg::ANGLE_W'(s0 + (f0 - s0) * s / steps);
      end
      send_item(hand_item(jmsd_pkg::MODE_SAMPLE, p, jmsd_pkg::KEEP_W'($urandom)));
    end
    for (int s = 0; s < hold; s++) begin
      for (int j = 0; j < JN; j++)
        p[j] = jmsd_pkg::ANGLE_W'(int'($signed(finish[j]))
                                  + rand_offset(int'(motion_tol) / 2));
      send_item(hand_item(jmsd_pkg::MODE_SAMPLE, p, jmsd_pkg::KEEP_W'($urandom)));
    end
  endtask

  task automatic send_noise(int n);
    hand_req_t r;
    for (int i = 0; i < n; i++) begin
      r.mode = jmsd_pkg::mode_t'($urandom_range(1));
      for (int j = 0; j < JN; j++) r.joint[j] = jmsd_pkg::ANGLE_W'($urandom);
      r.keep = jmsd_pkg::KEEP_W'($urandom);
      send_item(r);
    end
  endtask

  task automatic test_directed_cases();
    pose_t mix;
    mix = {16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF};
    send_item(hand_item(jmsd_pkg::MODE_COMMAND, flat_pose(32767), 7'h2A));
    send_item(hand_item(jmsd_pkg::MODE_SAMPLE, mix, 7'h7F));
    send_item(hand_item(jmsd_pkg::MODE_COMMAND, ~mix, 7'h7F));
    send_item(hand_item(jmsd_pkg::MODE_SAMPLE, mix, 7'h00));
    send_item(hand_item(jmsd_pkg::MODE_COMMAND, flat_pose(0), 7'h00));
    send_item(hand_item(jmsd_pkg::MODE_SAMPLE, ~mix, 7'h55));
    for (int i = 0; i < 11; i++) send_item(hand_item(jmsd_pkg::MODE_SAMPLE, ~mix, 7'h00));
    send_item(hand_item(jmsd_pkg::MODE_COMMAND, flat_pose(1000), 7'h00));
    send_item(hand_item(jmsd_pkg::MODE_SAMPLE, flat_pose(1000 + 123), 7'h00));
    send_item(hand_item(jmsd_pkg::MODE_SAMPLE, flat_pose(1000 + 124), 7'h00));
    send_item(hand_item(jmsd_pkg::MODE_SAMPLE, flat_pose(1000 - 124), 7'h00));
  endtask

  task automatic test_tolerance_phase(logic [jmsd_pkg::TOL_W-1:0] reach,
                                      logic [jmsd_pkg::TOL_W-1:0] motion,
                                      int in_pct, int out_pct);
    int stop_at;
    int pick;
    settle_drain();
    write_tolerances(reach, motion);
    in_idle_pct = in_pct;
    out_stall_pct = out_pct;
    stop_at = items_sent + PHASE_SIZE;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 78) send_move(1'b0);
      else if (pick < 90) send_noise($urandom_range(1, 4));
      else send_move(1'b1);
    end
  endtask

  task automatic test_output_hold();
    settle_drain();
    in_idle_pct = 0;
    out_stall_pct = 0;
    hold_left = 300;
    send_move(1'b0);
    send_noise(6);
    settle_drain();
    send_move(1'b0);
    settle_drain();
  endtask

  // result checker and ready driver
  initial begin
    jmsd_pkg::result_t exp_r;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (status_due.size() == 0) begin
          note_mismatch("result with no request pending", 0, 1);
        end else begin
          exp_r = status_due.pop_front();
          if (out_ch.target_reached !== exp_r.target_reached)
            note_mismatch("target_reached", exp_r.target_reached, out_ch.target_reached);
          if (out_ch.motion_started !== exp_r.motion_started)
            note_mismatch("motion_started", exp_r.motion_started, out_ch.motion_started);
          if (out_ch.still_moving !== exp_r.still_moving)
            note_mismatch("still_moving", exp_r.still_moving, out_ch.still_moving);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_CAP) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("joint_motion_settle_detector_core regression: fail");
    $finish;
  end

  initial begin
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= jmsd_pkg::REG_REACH_TOL;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.mode      <= jmsd_pkg::MODE_SAMPLE;
    in_ch.joint0    <= '0;
    in_ch.joint1    <= '0;
    in_ch.joint2    <= '0;
    in_ch.joint3    <= '0;
    in_ch.joint4    <= '0;
    in_ch.joint5    <= '0;
    in_ch.joint6    <= '0;
    in_ch.keep_mask <= '0;
    out_ch.ready    <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_tolerance_phase(jmsd_pkg::REACH_TOL_RST, jmsd_pkg::MOTION_TOL_RST, 0, 0);
    test_tolerance_phase('0, '0, 82, 0);
    test_tolerance_phase('1, '1, 0, 82);
    test_tolerance_phase(jmsd_pkg::TOL_W'($urandom_range(1, 2000)),
                         jmsd_pkg::TOL_W'($urandom_range(1, 400)), 15, 15);
    test_tolerance_phase(jmsd_pkg::TOL_W'(400), jmsd_pkg::TOL_W'(60), 0, 0);
    test_output_hold();
    settle_drain();
    repeat (20) @(posedge clk);
    if (err_cnt == 0 && status_due.size() == 0)
      $display("joint_motion_settle_detector_core regression: pass");
    else
      $display("joint_motion_settle_detector_core regression: fail");
    $finish;
  end

endmodule

// File: joint_motion_settle_detector_core.f
sv/jmsd_pkg.sv
sv/jmsd_if.sv
sv/jmsd_dev_unit.sv
sv/jmsd_hist_mem.sv
sv/joint_motion_settle_detector_core.sv
tb/tb_top.sv
